// File: hdl/ipv4_rhc_pkg.sv
// Shared types, codes and helpers of the IPv4 receive header check.
package ipv4_rhc_pkg;

  // Header layout and fixed values
  localparam logic [5:0]  HEADER_MIN_BYTES = 6'd20;
  localparam logic [3:0]  VERSION_IPV4     = 4'd4;
  localparam logic [7:0]  PROTO_ICMP       = 8'd1;
  localparam logic [7:0]  PROTO_TCP        = 8'd6;
  localparam logic [7:0]  PROTO_UDP        = 8'd17;
  localparam logic [16:0] SUM_ALL_ONES     = 17'h0FFFF;

  // Byte positions inside the fixed header
  localparam int unsigned POS_VHL          = 0;
  localparam int unsigned POS_TOTAL_HI     = 2;
  localparam int unsigned POS_TOTAL_LO     = 3;
  localparam int unsigned POS_PROTOCOL     = 9;
  localparam int unsigned POS_SOURCE_FIRST = 12;
  localparam int unsigned POS_SOURCE_LAST  = 15;
  localparam int unsigned POS_DEST_FIRST   = 16;
  localparam int unsigned POS_DEST_LAST    = 19;

  typedef enum logic [2:0] {
    VERDICT_OK,
    VERDICT_SHORT,
    VERDICT_VERSION,
    VERDICT_IHL,
    VERDICT_CHECKSUM,
    VERDICT_NOT_OURS,
    VERDICT_TRUNCATED,
    VERDICT_TOTAL_BELOW_IHL
  } verdict_t;

  typedef enum logic [1:0] {
    CLASS_ICMP,
    CLASS_UDP,
    CLASS_TCP,
    CLASS_OTHER
  } proto_class_t;

  // Everything the verdict stage needs about one finished frame
  typedef struct packed {
    logic [15:0] frame_length;
    logic [7:0]  vhl_byte;
    logic [15:0] datagram_len;
    logic [7:0]  protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic        sum_ok;
  } frame_rec_t;

  // Header length in bytes from the version/IHL byte
  function automatic logic [5:0] header_bytes(input logic [7:0] vhl);
    return {vhl[3:0], 2'b00};
  endfunction

endpackage

// File: hdl/ipv4_rhc_in_if.sv
// Byte stream channel into the header check.
interface ipv4_rhc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

// File: hdl/ipv4_rhc_out_if.sv
// Result channel out of the header check.
interface ipv4_rhc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [1:0]  protocol_class;
  logic [31:0] source_address;
  logic [5:0]  payload_offset;
  logic [15:0] payload_length;
  logic [15:0] frame_length;

  modport source (
    output valid, output verdict, output protocol_class, output source_address,
    output payload_offset, output payload_length, output frame_length, input ready
  );
  modport sink (
    input valid, input verdict, input protocol_class, input source_address,
    input payload_offset, input payload_length, input frame_length, output ready
  );
endinterface

// File: hdl/ipv4_receive_header_check.sv
// The last byte pushes a record; the result register loads once it is popped.
// Throughput: one byte per cycle; a two-record queue decouples parsing from the
// verdict stage, so one-byte frames still stream at one per cycle.
// The input stalls while the queue holds two records, after a result was held back.
// Reset (rst, synchronous) clears the frame state, the queue, the result valid
// and the local address register.
module ipv4_receive_header_check #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  logic [31:0]    cfg_wr_data,
  ipv4_rhc_in_if.sink    frame_in,
  ipv4_rhc_out_if.source result_out
);

  logic [31:0]              local_address;
  logic                     push;
  ipv4_rhc_pkg::frame_rec_t push_rec;
  logic                     queue_full;
  logic                     queue_empty;
  logic                     pop;
  ipv4_rhc_pkg::frame_rec_t pop_rec;

  // Hold this host's address
  always_ff @(posedge clk) begin
    if (rst) begin
      local_address <= '0;
    end else if (cfg_wr_en) begin
      local_address <= cfg_wr_data;
    end
  end

  ipv4_rhc_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .frame_in   (frame_in),
    .queue_full (queue_full),
    .push       (push),
    .push_rec   (push_rec)
  );

  ipv4_rhc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (queue_full),
    .empty    (queue_empty),
    .pop      (pop),
    .pop_rec  (pop_rec)
  );

  ipv4_rhc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .local_address (local_address),
    .queue_empty   (queue_empty),
    .rec           (pop_rec),
    .pop           (pop),
    .result_out    (result_out)
  );

endmodule

// File: hdl/ipv4_rhc_front.sv
// Front part: parses header bytes, keeps the checksum and pushes a record per frame.
module ipv4_rhc_front #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  ipv4_rhc_in_if.sink              frame_in,
  input  logic                     queue_full,
  output logic                     push,
  output ipv4_rhc_pkg::frame_rec_t push_rec
);

  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

  logic [LENGTH_BITS-1:0] byte_count;
  logic [16:0]            sum_acc;
  logic [7:0]             high_byte_hold;
  logic [7:0]             vhl_byte;
  logic [15:0]            datagram_len;
  logic [7:0]             protocol;
  logic [31:0]            source_address;
  logic [31:0]            dest_address;
  logic                   sum_ok;

  logic [LENGTH_BITS-1:0] byte_count_next;
  logic [16:0]            sum_acc_next;
  logic [7:0]             high_byte_hold_next;
  logic [7:0]             vhl_byte_next;
  logic [15:0]            datagram_len_next;
  logic [7:0]             protocol_next;
  logic [31:0]            source_address_next;
  logic [31:0]            dest_address_next;
  logic                   sum_ok_next;

  logic                   accept;
  logic [7:0]             b;
  logic [5:0]             hdr_len;
  logic                   in_header;
  logic [17:0]            sum_wide;
  logic [16:0]            sum_fold;

  assign frame_in.ready = !queue_full;
  assign accept         = frame_in.valid && frame_in.ready;
  assign push           = accept && frame_in.frame_last;
  assign b              = frame_in.frame_byte;

  // Add the current header word with end-around carry
  assign sum_wide = {1'b0, sum_acc} + {2'b00, high_byte_hold, b};
  assign sum_fold = {1'b0, sum_wide[15:0]} + {15'd0, sum_wide[17:16]};

  // Work out the state after this byte
  always_comb begin
    byte_count_next     = byte_count;
    sum_acc_next        = sum_acc;
    high_byte_hold_next = high_byte_hold;
    vhl_byte_next       = vhl_byte;
    datagram_len_next   = datagram_len;
    protocol_next       = protocol;
    source_address_next = source_address;
    dest_address_next   = dest_address;
    sum_ok_next         = sum_ok;

    if (byte_count == LENGTH_BITS'(ipv4_rhc_pkg::POS_VHL)) begin
      vhl_byte_next = b;
    end
    hdr_len   = ipv4_rhc_pkg::header_bytes(vhl_byte_next);
    in_header = byte_count < LENGTH_BITS'(hdr_len);

    if (in_header) begin
      if (!byte_count[0]) begin
        high_byte_hold_next = b;
      end else begin
        sum_acc_next = sum_fold;
        if (byte_count == LENGTH_BITS'(hdr_len - 6'd1)) begin
          sum_ok_next = (sum_fold == ipv4_rhc_pkg::SUM_ALL_ONES);
        end
      end
    end

    if (byte_count == LENGTH_BITS'(ipv4_rhc_pkg::POS_TOTAL_HI) ||
        byte_count == LENGTH_BITS'(ipv4_rhc_pkg::POS_TOTAL_LO)) begin
      datagram_len_next = {datagram_len[7:0], b};
    end else if (byte_count == LENGTH_BITS'(ipv4_rhc_pkg::POS_PROTOCOL)) begin
      protocol_next = b;
    end else if (byte_count >= LENGTH_BITS'(ipv4_rhc_pkg::POS_SOURCE_FIRST) &&
                 byte_count <= LENGTH_BITS'(ipv4_rhc_pkg::POS_SOURCE_LAST)) begin
      source_address_next = {source_address[23:0], b};
    end else if (byte_count >= LENGTH_BITS'(ipv4_rhc_pkg::POS_DEST_FIRST) &&
                 byte_count <= LENGTH_BITS'(ipv4_rhc_pkg::POS_DEST_LAST)) begin
      dest_address_next = {dest_address[23:0], b};
    end

    // Saturate the frame length
    if (byte_count != COUNT_MAX) begin
      byte_count_next = byte_count + LENGTH_BITS'(1);
    end
  end

  // Record of the finished frame, taken on the last byte
  always_comb begin
    push_rec.frame_length   = 16'(byte_count_next);
    push_rec.vhl_byte       = vhl_byte_next;
    push_rec.datagram_len   = datagram_len_next;
    push_rec.protocol       = protocol_next;
    push_rec.source_address = source_address_next;
    push_rec.dest_address   = dest_address_next;
    push_rec.sum_ok         = sum_ok_next;
  end

  // Advance on each transfer, clear after the last byte
  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_count     <= '0;
      sum_acc        <= '0;
      high_byte_hold <= '0;
      vhl_byte       <= '0;
      datagram_len   <= '0;
      protocol       <= '0;
      source_address <= '0;
      dest_address   <= '0;
      sum_ok         <= 1'b0;
    end else if (accept) begin
      byte_count     <= byte_count_next;
      sum_acc        <= sum_acc_next;
      high_byte_hold <= high_byte_hold_next;
      vhl_byte       <= vhl_byte_next;
      datagram_len   <= datagram_len_next;
      protocol       <= protocol_next;
      source_address <= source_address_next;
      dest_address   <= dest_address_next;
      sum_ok         <= sum_ok_next;
    end
  end

endmodule

// File: hdl/ipv4_rhc_queue.sv
// Two-entry queue of frame records between the parser and the verdict stage.
module ipv4_rhc_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  ipv4_rhc_pkg::frame_rec_t push_rec,
  output logic                     full,
  output logic                     empty,
  input  logic                     pop,
  output ipv4_rhc_pkg::frame_rec_t pop_rec
);

  ipv4_rhc_pkg::frame_rec_t entries [2];
  logic                     wr_ptr;
  logic                     rd_ptr;
  logic [1:0]               count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_rec = entries[rd_ptr];

  // Store pushed records
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/ipv4_rhc_back.sv
// Back part: judges each frame record and holds the result for transfer.
module ipv4_rhc_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [31:0]              local_address,
  input  logic                     queue_empty,
  input  ipv4_rhc_pkg::frame_rec_t rec,
  output logic                     pop,
  ipv4_rhc_out_if.source           result_out
);

  ipv4_rhc_pkg::verdict_t     verdict_next;
  ipv4_rhc_pkg::proto_class_t class_next;
  logic [5:0]                 hdr_len;
  logic [15:0]                hdr_len_wide;

  assign hdr_len      = ipv4_rhc_pkg::header_bytes(rec.vhl_byte);
  assign hdr_len_wide = {10'd0, hdr_len};

  // Take a record when the output slot is free or being emptied
  assign pop = !queue_empty && (!result_out.valid || result_out.ready);

  // Apply the checks in priority order
  always_comb begin
    if (rec.frame_length < {10'd0, ipv4_rhc_pkg::HEADER_MIN_BYTES}) begin
      verdict_next = ipv4_rhc_pkg::VERDICT_SHORT;
    end else if (rec.vhl_byte[7:4] != ipv4_rhc_pkg::VERSION_IPV4) begin
      verdict_next = ipv4_rhc_pkg::VERDICT_VERSION;
    end else if (hdr_len < ipv4_rhc_pkg::HEADER_MIN_BYTES ||
                 hdr_len_wide > rec.frame_length) begin
      verdict_next = ipv4_rhc_pkg::VERDICT_IHL;
    end else if (!rec.sum_ok) begin
      verdict_next = ipv4_rhc_pkg::VERDICT_CHECKSUM;
    end else if (rec.dest_address != local_address) begin
      verdict_next = ipv4_rhc_pkg::VERDICT_NOT_OURS;
    end else if (rec.datagram_len > rec.frame_length) begin
      verdict_next = ipv4_rhc_pkg::VERDICT_TRUNCATED;
    end else if (rec.datagram_len < hdr_len_wide) begin
      verdict_next = ipv4_rhc_pkg::VERDICT_TOTAL_BELOW_IHL;
    end else begin
      verdict_next = ipv4_rhc_pkg::VERDICT_OK;
    end
  end

  // Map the protocol number to a handler class
  always_comb begin
    unique case (rec.protocol)
      ipv4_rhc_pkg::PROTO_ICMP: class_next = ipv4_rhc_pkg::CLASS_ICMP;
      ipv4_rhc_pkg::PROTO_UDP:  class_next = ipv4_rhc_pkg::CLASS_UDP;
      ipv4_rhc_pkg::PROTO_TCP:  class_next = ipv4_rhc_pkg::CLASS_TCP;
      default:                  class_next = ipv4_rhc_pkg::CLASS_OTHER;
    endcase
  end

  // Hold the result until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (pop) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_out.verdict      <= verdict_next;
      result_out.frame_length <= rec.frame_length;
      if (verdict_next == ipv4_rhc_pkg::VERDICT_OK) begin
        result_out.protocol_class <= class_next;
        result_out.source_address <= rec.source_address;
        result_out.payload_offset <= hdr_len;
        result_out.payload_length <= rec.datagram_len - hdr_len_wide;
      end else begin
        result_out.protocol_class <= '0;
        result_out.source_address <= '0;
        result_out.payload_offset <= '0;
        result_out.payload_length <= '0;
      end
    end
  end

endmodule

// File: dv/tb_ipv4_receive_header_check.sv
// Testbench for the IPv4 receive header check: directed and random frames, byte predictor.
module tb_ipv4_receive_header_check;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEN_BITS     = 16;
  localparam int unsigned COUNT_MAX    = (1 << LEN_BITS) - 1;
  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned POS_CSUM_HI  = 10;
  localparam int unsigned POS_CSUM_LO  = 11;
  localparam int unsigned RANDOM_PHASE = 5;
  localparam int unsigned PHASE_BYTES  = 200;
  localparam logic [31:0] LAB_HOST     = 32'hC0A8_0A02;

  typedef struct {
    ipv4_rhc_pkg::verdict_t     verdict;
    ipv4_rhc_pkg::proto_class_t pclass;
    logic [31:0]                src_addr;
    logic [5:0]                 offset;
    logic [15:0]                plen;
    logic [15:0]                flen;
  } ip_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [31:0] cfg_wr_data;

  ipv4_rhc_in_if  frame_if();
  ipv4_rhc_out_if result_if();

  ipv4_receive_header_check #(
    .LENGTH_BITS(LEN_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .frame_in   (frame_if),
    .result_out (result_if)
  );

  // Parser state mirrored from the block, cleared after every last byte
  logic [15:0] rx_count;
  logic [16:0] rx_sum;
  logic [7:0]  rx_high;
  logic [7:0]  rx_vihl;
  logic [15:0] rx_total;
  logic [7:0]  rx_proto;
  logic [31:0] rx_src;
  logic [31:0] rx_dst;
  bit          rx_sum_ok;
  logic [31:0] host_addr;

  ip_result_t  pending[$];
  logic [7:0]  frame_buf[$];

  bit          idle_bursts;
  int unsigned cycle_count;
  int unsigned bytes_sent;
  int unsigned frames_sent;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned verdict_seen[8];

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Absorb one accepted byte; return 1 with the verdict when it closes a frame
  function automatic bit parse_rx_byte(input logic [7:0] b, input bit last,
                                       output ip_result_t r);
    int unsigned pos;
    int unsigned hlen;
    int unsigned flen;
    logic [16:0] s;
    ipv4_rhc_pkg::verdict_t     v;
    ipv4_rhc_pkg::proto_class_t pc;
    pos = rx_count;
    if (pos == ipv4_rhc_pkg::POS_VHL) rx_vihl = b;
    hlen = rx_vihl[3:0] * 4;

    // Fold each big-endian header word into the running sum
    if (pos < hlen) begin
      if (pos % 2 == 0) begin
        rx_high = b;
      end else begin
        s = rx_sum + {rx_high, b};
        s = s[15:0] + s[16];
        rx_sum = s;
        if (pos == hlen - 1) rx_sum_ok = (rx_sum == ipv4_rhc_pkg::SUM_ALL_ONES);
      end
    end

    if (pos == ipv4_rhc_pkg::POS_TOTAL_HI || pos == ipv4_rhc_pkg::POS_TOTAL_LO) begin
      rx_total = {rx_total[7:0], b};
    end else if (pos == ipv4_rhc_pkg::POS_PROTOCOL) begin
      rx_proto = b;
    end else if (pos >= ipv4_rhc_pkg::POS_SOURCE_FIRST &&
                 pos <= ipv4_rhc_pkg::POS_SOURCE_LAST) begin
      rx_src = {rx_src[23:0], b};
    end else if (pos >= ipv4_rhc_pkg::POS_DEST_FIRST &&
                 pos <= ipv4_rhc_pkg::POS_DEST_LAST) begin
      rx_dst = {rx_dst[23:0], b};
    end

    if (pos < COUNT_MAX) rx_count = 16'(pos + 1);
    if (!last) return 1'b0;

    // Verdict in priority order
    flen = rx_count;
    if (flen < ipv4_rhc_pkg::HEADER_MIN_BYTES) v = ipv4_rhc_pkg::VERDICT_SHORT;
    else if (rx_vihl[7:4] != ipv4_rhc_pkg::VERSION_IPV4) v = ipv4_rhc_pkg::VERDICT_VERSION;
    else if (hlen < ipv4_rhc_pkg::HEADER_MIN_BYTES || hlen > flen)
      v = ipv4_rhc_pkg::VERDICT_IHL;
    else if (!rx_sum_ok) v = ipv4_rhc_pkg::VERDICT_CHECKSUM;
    else if (rx_dst != host_addr) v = ipv4_rhc_pkg::VERDICT_NOT_OURS;
    else if (rx_total > flen) v = ipv4_rhc_pkg::VERDICT_TRUNCATED;
    else if (rx_total < hlen) v = ipv4_rhc_pkg::VERDICT_TOTAL_BELOW_IHL;
    else v = ipv4_rhc_pkg::VERDICT_OK;

    if (rx_proto == ipv4_rhc_pkg::PROTO_ICMP) pc = ipv4_rhc_pkg::CLASS_ICMP;
    else if (rx_proto == ipv4_rhc_pkg::PROTO_UDP) pc = ipv4_rhc_pkg::CLASS_UDP;
    else if (rx_proto == ipv4_rhc_pkg::PROTO_TCP) pc = ipv4_rhc_pkg::CLASS_TCP;
    else pc = ipv4_rhc_pkg::CLASS_OTHER;

    r.verdict = v;
    r.flen    = flen[15:0];
    if (v == ipv4_rhc_pkg::VERDICT_OK) begin
      r.pclass   = pc;
      r.src_addr = rx_src;
      r.offset   = hlen[5:0];
      r.plen     = rx_total - hlen[15:0];
    end else begin
      r.pclass   = ipv4_rhc_pkg::CLASS_ICMP;
      r.src_addr = '0;
      r.offset   = '0;
      r.plen     = '0;
    end

    rx_count  = '0;
    rx_sum    = '0;
    rx_high   = '0;
    rx_vihl   = '0;
    rx_total  = '0;
    rx_proto  = '0;
    rx_src    = '0;
    rx_dst    = '0;
    rx_sum_ok = 1'b0;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH result %0d %s: expected 0x%0h, got 0x%0h",
                 results_checked, name, want, got);
    end
  endtask

  // Compare every result transfer with the oldest expected verdict
  always @(posedge clk) begin
    ip_result_t exp_r;
    if (!rst && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH unexpected result, verdict %0d frame_length %0d",
                   result_if.verdict, result_if.frame_length);
      end else begin
        exp_r = pending.pop_front();
        check_field("verdict", exp_r.verdict, result_if.verdict);
        check_field("protocol_class", exp_r.pclass, result_if.protocol_class);
        check_field("source_address", exp_r.src_addr, result_if.source_address);
        check_field("payload_offset", exp_r.offset, result_if.payload_offset);
        check_field("payload_length", exp_r.plen, result_if.payload_length);
        check_field("frame_length", exp_r.flen, result_if.frame_length);
        verdict_seen[exp_r.verdict]++;
      end
      results_checked++;
    end
  end

  // Result side: take results, with random stall bursts while enabled
  initial begin
    result_if.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (idle_bursts && $urandom_range(0, 7) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      result_if.ready <= 1'b1;
    end
  end

  // Abort on a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending.size());
    $display("Verification failed");
    $finish;
  end

  // Send one byte, optionally after an idle burst; predict once it transfers
  task automatic send_byte(input logic [7:0] b, input bit last);
    int unsigned gap;
    ip_result_t  r;
    gap = (idle_bursts && $urandom_range(0, 9) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk);
    if (gap != 0) begin
      frame_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    frame_if.valid      <= 1'b1;
    frame_if.frame_byte <= b;
    frame_if.frame_last <= last;
    do @(posedge clk); while (frame_if.ready !== 1'b1);
    bytes_sent++;
    if (parse_rx_byte(b, last, r)) pending.push_back(r);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frames_sent++;
  endtask

  // Lay out a frame with random filler, fixed fields and optionally a good checksum
  task automatic build_frame(input logic [3:0] ver, input int unsigned ihl,
                             input logic [15:0] total, input logic [7:0] proto,
                             input logic [31:0] src, input logic [31:0] dst,
                             input int unsigned flen, input bit sum_good);
    int unsigned hlen;
    int unsigned fill;
    logic [16:0] acc;
    logic [15:0] csum;
    hlen = ihl * 4;
    fill = flen;
    if (fill < ipv4_rhc_pkg::HEADER_MIN_BYTES) fill = ipv4_rhc_pkg::HEADER_MIN_BYTES;
    if (fill < hlen) fill = hlen;
    frame_buf.delete();
    repeat (fill) frame_buf.push_back(8'($urandom));
    frame_buf[ipv4_rhc_pkg::POS_VHL]      = {ver, 4'(ihl)};
    frame_buf[ipv4_rhc_pkg::POS_TOTAL_HI] = total[15:8];
    frame_buf[ipv4_rhc_pkg::POS_TOTAL_LO] = total[7:0];
    frame_buf[ipv4_rhc_pkg::POS_PROTOCOL] = proto;
    for (int i = 0; i < 4; i++) begin
      frame_buf[ipv4_rhc_pkg::POS_SOURCE_FIRST + i] = src[31 - 8 * i -: 8];
      frame_buf[ipv4_rhc_pkg::POS_DEST_FIRST + i]   = dst[31 - 8 * i -: 8];
    end
    if (sum_good && hlen > POS_CSUM_LO) begin
      frame_buf[POS_CSUM_HI] = '0;
      frame_buf[POS_CSUM_LO] = '0;
      acc = '0;
      for (int i = 0; i + 1 < hlen; i += 2) begin
        acc = acc + {frame_buf[i], frame_buf[i + 1]};
        acc = acc[15:0] + acc[16];
      end
      csum = ~acc[15:0];
      frame_buf[POS_CSUM_HI] = csum[15:8];
      frame_buf[POS_CSUM_LO] = csum[7:0];
    end
    while (frame_buf.size() > flen) void'(frame_buf.pop_back());
  endtask

  // Lower valid, let every expected result arrive, then allow the pipeline to settle
  task automatic drain_results();
    @(negedge clk);
    frame_if.valid      <= 1'b0;
    frame_if.frame_last <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_host_address(input logic [31:0] addr);
    drain_results();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= addr;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    host_addr = addr;
  endtask

  // Mostly well-formed frames, some with one defect, a few pure noise
  task automatic make_random_frame();
    int unsigned kind;
    int unsigned ihl;
    int unsigned pay;
    int unsigned pad;
    int unsigned flen;
    int unsigned idx;
    logic [15:0] total;
    logic [7:0]  proto;
    logic [31:0] dst;
    logic [3:0]  ver;
    bit          corrupt;
    kind    = $urandom_range(0, 99);
    ihl     = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
    pay     = $urandom_range(0, 40);
    pad     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    total   = 16'(ihl * 4 + pay);
    flen    = total + pad;
    ver     = ipv4_rhc_pkg::VERSION_IPV4;
    dst     = host_addr;
    corrupt = 1'b0;
    case ($urandom_range(0, 3))
      0: proto = ipv4_rhc_pkg::PROTO_ICMP;
      1: proto = ipv4_rhc_pkg::PROTO_UDP;
      2: proto = ipv4_rhc_pkg::PROTO_TCP;
      default: proto = 8'($urandom);
    endcase

    if (kind >= 95) begin
      frame_buf.delete();
      repeat ($urandom_range(1, 64)) frame_buf.push_back(8'($urandom));
    end else begin
      if (kind >= 70) begin
        case ($urandom_range(0, 6))
          0: flen = $urandom_range(1, ipv4_rhc_pkg::HEADER_MIN_BYTES - 1);
          1: begin
            ver = 4'($urandom_range(0, 15));
            if (ver == ipv4_rhc_pkg::VERSION_IPV4) ver = 4'd0;
          end
          2: begin
            if ($urandom_range(0, 1) == 0) begin
              ihl = $urandom_range(0, 4);
            end else begin
              ihl  = $urandom_range(6, 15);
              flen = $urandom_range(ipv4_rhc_pkg::HEADER_MIN_BYTES, ihl * 4 - 1);
            end
          end
          3: corrupt = 1'b1;
          4: dst = host_addr ^ (32'h1 << $urandom_range(0, 31));
          5: total = 16'(flen + $urandom_range(1, 200));
          default: total = 16'($urandom_range(0, ihl * 4 - 1));
        endcase
      end
      build_frame(ver, ihl, total, proto, $urandom, dst, flen, 1'b1);
      if (corrupt) begin
        idx = $urandom_range(4, POS_CSUM_LO);
        if (idx == ipv4_rhc_pkg::POS_PROTOCOL) idx = POS_CSUM_HI;
        frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
      end
    end
  endtask

  // Address register at its reset value of zero
  task automatic test_reset_address();
    build_frame(ipv4_rhc_pkg::VERSION_IPV4, 5, 28, ipv4_rhc_pkg::PROTO_UDP, $urandom,
                32'h0, 28, 1'b1);
    send_frame();
    build_frame(ipv4_rhc_pkg::VERSION_IPV4, 5, 28, ipv4_rhc_pkg::PROTO_UDP, $urandom,
                32'h0A00_0001, 28, 1'b1);
    send_frame();
  endtask

  // One frame per verdict and per special case
  task automatic test_directed_verdicts();
    set_host_address(LAB_HOST);
    // short frames: one byte and one below the minimum header
    frame_buf = '{8'h45};
    send_frame();
    build_frame(ipv4_rhc_pkg::VERSION_IPV4, 5, 20, ipv4_rhc_pkg::PROTO_UDP, $urandom,
                LAB_HOST, 19, 1'b1);
    send_frame();
    // minimum valid frame, no payload
    build_frame(ipv4_rhc_pkg::VERSION_IPV4, 5, 20, ipv4_rhc_pkg::PROTO_ICMP, $urandom,
                LAB_HOST, 20, 1'b1);
    send_frame();
    // all-zero header
    frame_buf.delete();
    repeat (ipv4_rhc_pkg::HEADER_MIN_BYTES) frame_buf.push_back(8'h00);
    send_frame();
    // wrong version
    build_frame(4'd6, 5, 40, ipv4_rhc_pkg::PROTO_TCP, $urandom, LAB_HOST, 40, 1'b1);
    send_frame();
    // IHL too small, and larger than the frame
    build_frame(ipv4_rhc_pkg::VERSION_IPV4, 0, 40, ipv4_rhc_pkg::PROTO_TCP, $urandom,
                LAB_HOST, 40, 1'b1);
    send_frame();
    build_frame(ipv4_rhc_pkg::VERSION_IPV4, 4, 40, ipv4_rhc_pkg::PROTO_TCP, $urandom,
                LAB_HOST, 40, 1'b1);
    send_frame();
    build_frame(ipv4_rhc_pkg::VERSION_IPV4, 15, 40, ipv4_rhc_pkg::PROTO_TCP, $urandom,
                LAB_HOST, 40, 1'b1);
    send_frame();
    // bad checksum
    build_frame(ipv4_rhc_pkg::VERSION_IPV4, 5, 40, ipv4_rhc_pkg::PROTO_UDP, $urandom,
                LAB_HOST, 40, 1'b1);
    frame_buf[POS_CSUM_LO] = frame_buf[POS_CSUM_LO] ^ 8'h01;
    send_frame();
    // destination not this host
    build_frame(ipv4_rhc_pkg::VERSION_IPV4, 5, 40, ipv4_rhc_pkg::PROTO_UDP, $urandom,
                ~LAB_HOST, 40, 1'b1);
    send_frame();
    // total length one beyond the frame
    build_frame(ipv4_rhc_pkg::VERSION_IPV4, 5, 41, ipv4_rhc_pkg::PROTO_UDP, $urandom,
                LAB_HOST, 40, 1'b1);
    send_frame();
    // total length below the header length
    build_frame(ipv4_rhc_pkg::VERSION_IPV4, 5, 19, ipv4_rhc_pkg::PROTO_UDP, $urandom,
                LAB_HOST, 40, 1'b1);
    send_frame();
    build_frame(ipv4_rhc_pkg::VERSION_IPV4, 5, 0, ipv4_rhc_pkg::PROTO_UDP, $urandom,
                LAB_HOST, 20, 1'b1);
    send_frame();
    // largest header, options in the checksum
    build_frame(ipv4_rhc_pkg::VERSION_IPV4, 15, 68, ipv4_rhc_pkg::PROTO_TCP, $urandom,
                LAB_HOST, 68, 1'b1);
    send_frame();
    // unhandled protocols, extreme sources, trailing padding
    build_frame(ipv4_rhc_pkg::VERSION_IPV4, 5, 30, 8'h00, 32'h0, LAB_HOST, 36, 1'b1);
    send_frame();
    build_frame(ipv4_rhc_pkg::VERSION_IPV4, 5, 30, 8'hFF, 32'hFFFF_FFFF, LAB_HOST, 30,
                1'b1);
    send_frame();
    // a run of one-byte frames, which can fill the record queue
    repeat (8) begin
      frame_buf = '{8'($urandom)};
      send_frame();
    end
  endtask

  task automatic test_address_extremes();
    set_host_address(32'hFFFF_FFFF);
    build_frame(ipv4_rhc_pkg::VERSION_IPV4, 5, 32, ipv4_rhc_pkg::PROTO_UDP, $urandom,
                32'hFFFF_FFFF, 32, 1'b1);
    send_frame();
    build_frame(ipv4_rhc_pkg::VERSION_IPV4, 5, 32, ipv4_rhc_pkg::PROTO_UDP, $urandom,
                32'h0, 32, 1'b1);
    send_frame();
    build_frame(ipv4_rhc_pkg::VERSION_IPV4, 5, 16'hFFFF, ipv4_rhc_pkg::PROTO_TCP,
                $urandom, 32'hFFFF_FFFF, 24, 1'b1);
    send_frame();
    set_host_address(32'h0);
    build_frame(ipv4_rhc_pkg::VERSION_IPV4, 5, 24, ipv4_rhc_pkg::PROTO_ICMP, $urandom,
                32'h0, 24, 1'b1);
    send_frame();
    build_frame(ipv4_rhc_pkg::VERSION_IPV4, 5, 24, ipv4_rhc_pkg::PROTO_ICMP, $urandom,
                32'hFFFF_FFFF, 24, 1'b1);
    send_frame();
  endtask

  // Random traffic under several addresses; the last phase runs without idling
  task automatic test_random_traffic();
    int unsigned target;
    for (int phase = 0; phase < RANDOM_PHASE; phase++) begin
      set_host_address($urandom);
      idle_bursts = (phase < RANDOM_PHASE - 1);
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        make_random_frame();
        send_frame();
      end
    end
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    frame_if.valid      = 1'b0;
    frame_if.frame_byte = '0;
    frame_if.frame_last = 1'b0;
    idle_bursts         = 1'b1;
    host_addr           = '0;
    rx_count            = '0;
    rx_sum              = '0;
    rx_high             = '0;
    rx_vihl             = '0;
    rx_total            = '0;
    rx_proto            = '0;
    rx_src              = '0;
    rx_dst              = '0;
    rx_sum_ok           = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_address();
    test_directed_verdicts();
    test_address_extremes();
    test_random_traffic();
    drain_results();

    $display("Sent %0d frames (%0d bytes); checked %0d verdicts, %0d field mismatches",
             frames_sent, bytes_sent, results_checked, mismatches);
    $display("Verdicts seen: ok %0d short %0d version %0d ihl %0d checksum %0d",
             verdict_seen[ipv4_rhc_pkg::VERDICT_OK],
             verdict_seen[ipv4_rhc_pkg::VERDICT_SHORT],
             verdict_seen[ipv4_rhc_pkg::VERDICT_VERSION],
             verdict_seen[ipv4_rhc_pkg::VERDICT_IHL],
             verdict_seen[ipv4_rhc_pkg::VERDICT_CHECKSUM]);
    $display("  not ours %0d truncated %0d total below header %0d",
             verdict_seen[ipv4_rhc_pkg::VERDICT_NOT_OURS],
             verdict_seen[ipv4_rhc_pkg::VERDICT_TRUNCATED],
             verdict_seen[ipv4_rhc_pkg::VERDICT_TOTAL_BELOW_IHL]);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/ipv4_rhc_pkg.sv
hdl/ipv4_rhc_in_if.sv
hdl/ipv4_rhc_out_if.sv
hdl/ipv4_rhc_front.sv
hdl/ipv4_rhc_queue.sv
hdl/ipv4_rhc_back.sv
hdl/ipv4_receive_header_check.sv
dv/tb_ipv4_receive_header_check.sv
